// ===== sv/cc20_pkg.sv =====
// Shared types, constants and functions for the ChaCha20 block function.
// Used by every module of the block; no dependencies of its own.

package cc20_pkg;

  // Number of double rounds; each one is four pipeline steps (two half rounds each).
  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned NUM_STEPS     = 4 * DOUBLE_ROUNDS;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned NWORDS   = 16;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef logic [WORD_W-1:0]            word_t;
  typedef logic [NWORDS-1:0][WORD_W-1:0] state_t;
  typedef logic [IDX_W-1:0]             widx_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_01   = 3'd0,
    REG_KEY_23   = 3'd1,
    REG_KEY_45   = 3'd2,
    REG_KEY_67   = 3'd3,
    REG_NONCE_01 = 3'd4,
    REG_NONCE_2  = 3'd5
  } cfg_reg_t;

  // Key and nonce words as held by the configuration registers
  typedef struct packed {
    logic [7:0][WORD_W-1:0] key;
    logic [2:0][WORD_W-1:0] nonce;
  } cfg_t;

  // Per-stage control: which quarter-round set and which half of it
  typedef struct packed {
    logic diag;
    logic second;
  } step_t;

  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646E;
  localparam word_t SIGMA_2 = 32'h7962_2D32;
  localparam word_t SIGMA_3 = 32'h6B20_6574;

  localparam widx_t LAST_IDX = 4'd15;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    rotl = (x << n) | (x >> (WORD_W - n));
  endfunction

  // Initial state from constants, key, counter and nonce
  function automatic state_t init_state(input cfg_t cfg, input word_t ctr);
    state_t s;
    s[0]  = SIGMA_0;
    s[1]  = SIGMA_1;
    s[2]  = SIGMA_2;
    s[3]  = SIGMA_3;
    for (int i = 0; i < 8; i++) begin
      s[4+i] = cfg.key[i];
    end
    s[12] = ctr;
    s[13] = cfg.nonce[0];
    s[14] = cfg.nonce[1];
    s[15] = cfg.nonce[2];
    init_state = s;
  endfunction

  // Word positions a, b, c, d of quarter round q, column or diagonal set
  function automatic logic [3:0][IDX_W-1:0] quad_idx(input logic diag, input int unsigned q);
    logic [3:0][IDX_W-1:0] r;
    r[0] = IDX_W'(q);
    if (diag) begin
      r[1] = IDX_W'(4 + ((q + 1) % 4));
      r[2] = IDX_W'(8 + ((q + 2) % 4));
      r[3] = IDX_W'(12 + ((q + 3) % 4));
    end else begin
      r[1] = IDX_W'(4 + q);
      r[2] = IDX_W'(8 + q);
      r[3] = IDX_W'(12 + q);
    end
    quad_idx = r;
  endfunction

  // Half of a quarter round on words {a, b, c, d} (index 0 = a)
  function automatic logic [3:0][WORD_W-1:0] qr_half(input logic [3:0][WORD_W-1:0] v,
                                                      input logic second);
    word_t a, b, c, d;
    a = v[0];
    b = v[1];
    c = v[2];
    d = v[3];
    a = a + b;
    d = rotl(d ^ a, second ? 8 : 16);
    c = c + d;
    b = rotl(b ^ c, second ? 7 : 12);
    qr_half = {d, c, b, a};
  endfunction

endpackage

// ===== sv/cc20_round_stage.sv =====
// One pipeline stage: half of four parallel quarter rounds, registered.
// Depends on cc20_pkg.

module cc20_round_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  cc20_pkg::step_t step,
  input  logic            vld_in,
  input  cc20_pkg::state_t st_in,
  input  cc20_pkg::word_t  ctr_in,
  output logic            vld_out,
  output cc20_pkg::state_t st_out,
  output cc20_pkg::word_t  ctr_out
);
  import cc20_pkg::*;

  logic   vld_r;
  state_t st_r;
  word_t  ctr_r;
  state_t st_nxt;

  // Four independent quarter-round halves
  always_comb begin
    logic [3:0][IDX_W-1:0]  ix;
    logic [3:0][WORD_W-1:0] v;
    logic [3:0][WORD_W-1:0] o;
    st_nxt = st_in;
    for (int q = 0; q < 4; q++) begin
      ix = quad_idx(step.diag, q);
      for (int j = 0; j < 4; j++) begin
        v[j] = st_in[ix[j]];
      end
      o = qr_half(v, step.second);
      for (int j = 0; j < 4; j++) begin
        st_nxt[ix[j]] = o[j];
      end
    end
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r  <= st_nxt;
      ctr_r <= ctr_in;
    end
  end

  assign vld_out = vld_r;
  assign st_out  = st_r;
  assign ctr_out = ctr_r;

endmodule

// ===== sv/cc20_core.sv =====
// Round pipeline: initial-state register followed by the half-round stages.
// Depends on cc20_pkg and cc20_round_stage.

module cc20_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  cc20_pkg::cfg_t   cfg,
  input  logic             in_vld,
  input  cc20_pkg::word_t  in_ctr,
  output logic             out_vld,
  output cc20_pkg::state_t out_st,
  output cc20_pkg::word_t  out_ctr
);
  import cc20_pkg::*;

  logic   vld_w [0:NUM_STEPS];
  state_t st_w  [0:NUM_STEPS];
  word_t  ctr_w [0:NUM_STEPS];

  logic   vld0_r;
  state_t st0_r;
  word_t  ctr0_r;

  // Entry stage builds the initial state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st0_r  <= init_state(cfg, in_ctr);
      ctr0_r <= in_ctr;
    end
  end

  assign vld_w[0] = vld0_r;
  assign st_w[0]  = st0_r;
  assign ctr_w[0] = ctr0_r;

  // Two stages per single round; rounds alternate column and diagonal
  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
    localparam bit DIAG   = ((k / 2) % 2) == 1;
    localparam bit SECOND = (k % 2) == 1;
    step_t step;
    assign step.diag   = DIAG;
    assign step.second = SECOND;

    cc20_round_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .step    (step),
      .vld_in  (vld_w[k]),
      .st_in   (st_w[k]),
      .ctr_in  (ctr_w[k]),
      .vld_out (vld_w[k+1]),
      .st_out  (st_w[k+1]),
      .ctr_out (ctr_w[k+1])
    );
  end

  assign out_vld = vld_w[NUM_STEPS];
  assign out_st  = st_w[NUM_STEPS];
  assign out_ctr = ctr_w[NUM_STEPS];

endmodule

// ===== sv/cc20_out.sv =====
// Output stage: final add of the initial state, then word-by-word serializer.
// Depends on cc20_pkg.

module cc20_out (
  input  logic             clk,
  input  logic             rst_n,
  input  cc20_pkg::cfg_t   cfg,
  input  logic             blk_vld,
  input  cc20_pkg::state_t blk_st,
  input  cc20_pkg::word_t  blk_ctr,
  output logic             adv,
  output logic             out_valid,
  input  logic             out_stall,
  output cc20_pkg::widx_t  out_word_index,
  output cc20_pkg::word_t  out_keystream_word,
  output logic             out_last_word
);
  import cc20_pkg::*;

  logic   hold_r;
  widx_t  idx_r;
  state_t words_r;
  state_t init_w;
  logic   xfer;
  logic   done;
  logic   load;

  assign init_w = init_state(cfg, blk_ctr);

  // Handshake: a block loads when the buffer is empty or finishing its last word
  assign xfer = hold_r && !out_stall;
  assign done = xfer && (idx_r == LAST_IDX);
  assign load = blk_vld && (!hold_r || done);
  assign adv  = !blk_vld || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      hold_r <= 1'b1;
      idx_r  <= '0;
    end else if (done) begin
      hold_r <= 1'b0;
      idx_r  <= '0;
    end else if (xfer) begin
      idx_r  <= idx_r + widx_t'(1);
    end
  end

  // Feed-forward add of the initial state
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NWORDS; i++) begin
        words_r[i] <= blk_st[i] + init_w[i];
      end
    end
  end

  assign out_valid          = hold_r;
  assign out_word_index     = idx_r;
  assign out_keystream_word = words_r[idx_r];
  assign out_last_word      = (idx_r == LAST_IDX);

endmodule

// ===== sv/chacha20_block_function.sv =====
// ChaCha20 block function top level: configuration registers and wiring.
// Depends on cc20_pkg, cc20_core and cc20_out.
//
// Usage:
//   Configuration: write key and nonce over cfg_valid/cfg_ready with cfg_index
//   and cfg_data. Index 0..3 hold key word pairs (even word in bits 31:0),
//   index 4 nonce words 0 and 1, index 5 nonce word 2 (bits 31:0). Other
//   indexes are ignored. cfg_ready is always high. Write only while idle.
//   Input: one transaction per block counter on in_valid/in_stall.
//   Output: sixteen transactions per block on out_valid/out_stall, word_index
//   0 to 15 in order, out_last_word high on word 15.
//   Path: a counter is taken into the entry register at the accepting edge,
//   then passes the 40 half-round stages and the registered feed-forward add
//   before the first word of its block is presented.
//   Throughput: the output port sends one word per cycle while out_stall is
//   low; up to 41 blocks wait in the round pipeline, one more in the buffer.
//   Stall: a finished block waits at the end of the round pipeline while the
//   output buffer still sends the previous block; meanwhile the whole
//   pipeline holds and in_stall is high.
//   Reset: clears all valid bits and the key/nonce registers to zero.

module chacha20_block_function (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cc20_pkg::word_t                     in_block_counter,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cc20_pkg::widx_t                     out_word_index,
  output cc20_pkg::word_t                     out_keystream_word,
  output logic                                out_last_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cc20_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cc20_pkg::*;

  cfg_t   cfg_r;
  logic   adv;
  logic   blk_vld;
  state_t blk_st;
  word_t  blk_ctr;

  assign cfg_ready = 1'b1;

  // Configuration register decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY_01: begin
          cfg_r.key[0] <= cfg_data[31:0];
          cfg_r.key[1] <= cfg_data[63:32];
        end
        REG_KEY_23: begin
          cfg_r.key[2] <= cfg_data[31:0];
          cfg_r.key[3] <= cfg_data[63:32];
        end
        REG_KEY_45: begin
          cfg_r.key[4] <= cfg_data[31:0];
          cfg_r.key[5] <= cfg_data[63:32];
        end
        REG_KEY_67: begin
          cfg_r.key[6] <= cfg_data[31:0];
          cfg_r.key[7] <= cfg_data[63:32];
        end
        REG_NONCE_01: begin
          cfg_r.nonce[0] <= cfg_data[31:0];
          cfg_r.nonce[1] <= cfg_data[63:32];
        end
        REG_NONCE_2: begin
          cfg_r.nonce[2] <= cfg_data[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall = !adv;

  // Round pipeline
  cc20_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cfg     (cfg_r),
    .in_vld  (in_valid),
    .in_ctr  (in_block_counter),
    .out_vld (blk_vld),
    .out_st  (blk_st),
    .out_ctr (blk_ctr)
  );

  // Feed-forward add and word serializer
  cc20_out u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .blk_vld            (blk_vld),
    .blk_st             (blk_st),
    .blk_ctr            (blk_ctr),
    .adv                (adv),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_word_index     (out_word_index),
    .out_keystream_word (out_keystream_word),
    .out_last_word      (out_last_word)
  );

  // Input is held off only when a finished block waits behind a busy output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (blk_vld && out_valid))
    else $error("in_stall without a waiting block and busy output");

  // Words of a block follow in order
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + widx_t'(1)))
    else $error("keystream words out of order or block broken off");

  // A new block always starts at word 0
  a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid) || $past(out_valid && !out_stall && out_last_word)) && out_valid
      |-> out_word_index == '0)
    else $error("block did not start at word 0");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the ChaCha20 block function (chacha20_block_function).
// Depends on cc20_pkg and the block's RTL; predicts every keystream word internally.

module testbench;
  import cc20_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned PHASES = 6;
  localparam int unsigned ITEMS_PER_PHASE = 28;

  // Register indexes beyond the implemented set; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    widx_t word_index;
    word_t keystream_word;
    logic  last_word;
  } ks_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  word_t                 in_block_counter;
  logic                  out_valid;
  logic                  out_stall;
  widx_t                 out_word_index;
  word_t                 out_keystream_word;
  logic                  out_last_word;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of key and nonce as the block should hold them
  word_t       key_model [8];
  word_t       nonce_model [3];
  ks_word_t    expected_words [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned stall_run;
  bit          allow_gaps;

  chacha20_block_function i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_block_counter   (in_block_counter),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_word_index     (out_word_index),
    .out_keystream_word (out_keystream_word),
    .out_last_word      (out_last_word),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!allow_gaps) return 0;
    roll = $urandom_range(99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  function automatic word_t rol_word(input word_t v, input int n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  // Compute the 16 keystream words of one block and queue them
  function automatic void predict_block(input word_t counter);
    word_t    start [16];
    word_t    x [16];
    int       a, b, c, d, qi, sh;
    ks_word_t item;
    start[0] = SIGMA_0;
    start[1] = SIGMA_1;
    start[2] = SIGMA_2;
    start[3] = SIGMA_3;
    for (int i = 0; i < 8; i++) start[4+i] = key_model[i];
    start[12] = counter;
    for (int i = 0; i < 3; i++) start[13+i] = nonce_model[i];
    x = start;
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      // q 0..3: columns, q 4..7: diagonals
      for (int q = 0; q < 8; q++) begin
        qi = q % 4;
        sh = q / 4;
        a = qi;
        b = 4 + (qi + sh) % 4;
        c = 8 + (qi + 2 * sh) % 4;
        d = 12 + (qi + 3 * sh) % 4;
        x[a] += x[b]; x[d] = rol_word(x[d] ^ x[a], 16);
        x[c] += x[d]; x[b] = rol_word(x[b] ^ x[c], 12);
        x[a] += x[b]; x[d] = rol_word(x[d] ^ x[a], 8);
        x[c] += x[d]; x[b] = rol_word(x[b] ^ x[c], 7);
      end
    end
    for (int i = 0; i < 16; i++) begin
      item.word_index     = widx_t'(i);
      item.keystream_word = x[i] + start[i];
      item.last_word      = (widx_t'(i) == LAST_IDX);
      expected_words.push_back(item);
    end
  endfunction

  // Counter stream: mostly sequential, some random, some near the ends
  function automatic word_t pick_counter(input word_t prev);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return prev + 1;
    if (roll < 75) return word_t'($urandom);
    if (roll < 88) return word_t'($urandom_range(15));
    return ~word_t'($urandom_range(15));
  endfunction

  // Receiver: random stall runs
  always @(posedge clk) begin
    if (!rst_n || !allow_gaps) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run != 0) begin
      stall_run = stall_run - 1;
    end else begin
      out_stall <= ($urandom_range(99) < 30);
      stall_run = pick_gap();
    end
  end

  // Compare each output transaction with the oldest predicted word
  always @(posedge clk) begin
    ks_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected keystream word %h at word_index %0d", out_keystream_word,
               out_word_index);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_word_index !== want.word_index) begin
          $error("word_index: expected %0d, actual %0d", want.word_index, out_word_index);
          error_count++;
        end
        if (out_keystream_word !== want.keystream_word) begin
          $error("keystream_word: expected %h, actual %h", want.keystream_word,
                 out_keystream_word);
          error_count++;
        end
        if (out_last_word !== want.last_word) begin
          $error("last_word: expected %0b, actual %0b", want.last_word, out_last_word);
          error_count++;
        end
      end
    end
  end

  // One config transaction; more=1 keeps valid high for a following write
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data, input bit more);
    int slot;
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (!more) cfg_valid <= 1'b0;
    slot = 2 * int'(index);
    case (index) inside
      REG_KEY_01, REG_KEY_23, REG_KEY_45, REG_KEY_67: begin
        key_model[slot]   = data[31:0];
        key_model[slot+1] = data[63:32];
      end
      REG_NONCE_01: begin
        nonce_model[0] = data[31:0];
        nonce_model[1] = data[63:32];
      end
      REG_NONCE_2: nonce_model[2] = data[31:0];
      default: ;  // unimplemented index, no effect
    endcase
  endtask

  task automatic load_uniform(input logic [CFG_DATA_W-1:0] value);
    for (int i = REG_KEY_01; i <= REG_NONCE_2; i++)
      write_register(CFG_IDX_W'(i), value, i != REG_NONCE_2);
  endtask

  task automatic load_random_keys();
    for (int i = REG_KEY_01; i <= REG_NONCE_2; i++)
      write_register(CFG_IDX_W'(i), {$urandom, $urandom}, i != REG_NONCE_2);
  endtask

  // One input transaction, preceded by a random gap
  task automatic send_counter(input word_t counter);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_block_counter <= counter;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_block(counter);
  endtask

  // Drop valid and wait until every predicted word has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Registers at their reset value (all zero), back-to-back counters
  task automatic test_reset_defaults();
    allow_gaps = 1'b0;
    for (int i = 0; i < 8; i++) key_model[i] = '0;
    for (int i = 0; i < 3; i++) nonce_model[i] = '0;
    send_counter(32'h0000_0000);
    send_counter(32'hFFFF_FFFF);
    send_counter(32'h0000_0001);
  endtask

  // Known-answer block: key 00..1f, nonce 000000090000004a00000000, counter 1
  task automatic test_known_answer();
    wait_idle();
    allow_gaps = 1'b1;
    write_register(REG_KEY_01,   {32'h0706_0504, 32'h0302_0100}, 1'b1);
    write_register(REG_KEY_23,   {32'h0F0E_0D0C, 32'h0B0A_0908}, 1'b1);
    write_register(REG_KEY_45,   {32'h1716_1514, 32'h1312_1110}, 1'b1);
    write_register(REG_KEY_67,   {32'h1F1E_1D1C, 32'h1B1A_1918}, 1'b1);
    write_register(REG_NONCE_01, {32'h4A00_0000, 32'h0900_0000}, 1'b1);
    write_register(REG_NONCE_2,  64'h0, 1'b0);
    send_counter(32'h0000_0001);
    // sanity of the predictor itself against the published first word
    if (expected_words[0].keystream_word !== 32'hE4E7_F110) begin
      $error("keystream_word: expected %h, actual %h", 32'hE4E7_F110,
             expected_words[0].keystream_word);
      error_count++;
    end
    send_counter(32'h0000_0000);
  endtask

  // All-ones and all-zeros register contents, counter bit patterns
  task automatic test_register_extremes();
    wait_idle();
    load_uniform('1);
    send_counter(32'h0000_0000);
    send_counter(32'hFFFF_FFFF);
    send_counter(32'hAAAA_AAAA);
    send_counter(32'h5555_5555);
    wait_idle();
    load_uniform('0);
    send_counter(32'h8000_0000);
  endtask

  // Writes to unimplemented indexes and upper bits of nonce word 2 are dropped
  task automatic test_ignored_writes();
    wait_idle();
    load_random_keys();
    @(posedge clk);
    write_register(CFG_IDX_SPARE_LO, '1, 1'b1);
    write_register(CFG_IDX_SPARE_HI, '1, 1'b1);
    write_register(REG_NONCE_2, {32'hFFFF_FFFF, 32'h0000_0000}, 1'b0);
    send_counter(32'h7FFF_FFFF);
    send_counter(word_t'($urandom));
    send_counter(32'hFFFF_FFFE);
  endtask

  // Phases of random traffic, each with fresh key and nonce
  task automatic test_random_traffic();
    word_t counter;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      allow_gaps = (phase != 2);  // one phase at full rate, no stalls
      load_random_keys();
      counter = word_t'($urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        counter = pick_counter(counter);
        send_counter(counter);
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_block_counter = '0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    error_count      = 0;
    cycle_count      = 0;
    stall_run        = 0;
    allow_gaps       = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_known_answer();
    test_register_extremes();
    test_ignored_writes();
    test_random_traffic();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cc20_pkg.sv
sv/cc20_round_stage.sv
sv/cc20_core.sv
sv/cc20_out.sv
sv/chacha20_block_function.sv
dv/testbench.sv
